@@ sv/srde_pkg.sv @@
package srde_pkg;

  // Fixed widths of the item fields
  localparam int FIELD_BITS   = 16;
  localparam int INDEX_BITS   = 16;
  localparam int IDX_SEL_BITS = 4;
  localparam int WEIGHT_BITS  = 5;
  localparam int WEIGHT_MAX   = 31;

  // Rotation amounts of the round function
  localparam int ROT_AND_A = 1;
  localparam int ROT_AND_B = 8;
  localparam int ROT_XOR   = 2;

  // Tie detection: look-ahead tap and partner distance
  localparam int TIE_LOOK = 6;
  localparam int TIE_STEP = 7;

  // Bit positions handled by one fill stage
  localparam int FILL_LANES = 8;

  // One input word as it travels down the pipeline
  typedef struct packed {
    logic [FIELD_BITS-1:0] left_diff;
    logic [FIELD_BITS-1:0] right_diff;
    logic [FIELD_BITS-1:0] choice_index;
  } item_t;

endpackage

@@ sv/srde_scan_stage.sv @@
module srde_scan_stage import srde_pkg::*; #(
  parameter int WORD_BITS = 16,
  parameter int SLOT_BITS = 4,
  parameter int CNT_BITS  = 5,
  parameter int STEP      = 0
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  item_t                               item_i,
  input  logic [WORD_BITS-1:0]                linked_i,
  input  logic [WORD_BITS-1:0][SLOT_BITS-1:0] slot_i,
  input  logic [CNT_BITS-1:0]                 cnt_i,
  output logic                                valid_o,
  output item_t                               item_o,
  output logic [WORD_BITS-1:0]                linked_o,
  output logic [WORD_BITS-1:0][SLOT_BITS-1:0] slot_o,
  output logic [CNT_BITS-1:0]                 cnt_o
);

  localparam int P1 = (STEP + WORD_BITS - ROT_AND_A) % WORD_BITS;
  localparam int P8 = (STEP + WORD_BITS - ROT_AND_B) % WORD_BITS;
  localparam int P6 = (STEP + TIE_LOOK) % WORD_BITS;
  localparam int PT = (STEP + TIE_STEP) % WORD_BITS;

  logic [WORD_BITS-1:0]                left_w;
  logic                                s1_w, s8_w, s6_w, counts_w, tie_w;
  logic                                valid_q;
  item_t                               item_q;
  logic [WORD_BITS-1:0]                linked_d, linked_q;
  logic [WORD_BITS-1:0][SLOT_BITS-1:0] slot_d, slot_q;
  logic [CNT_BITS-1:0]                 cnt_d, cnt_q;

  // Tap the zero-extended left difference
  assign left_w   = WORD_BITS'(item_i.left_diff);
  assign s1_w     = left_w[P1];
  assign s8_w     = left_w[P8];
  assign s6_w     = left_w[P6];
  assign counts_w = s1_w | s8_w;
  assign tie_w    = ~s1_w & s6_w & s8_w;

  // Apply one scan step: open a slot, link the partner, or drop the bit
  always_comb begin
    linked_d = linked_i;
    slot_d   = slot_i;
    if (counts_w) begin
      if (!linked_i[STEP]) begin
        linked_d[STEP] = 1'b1;
        slot_d[STEP]   = SLOT_BITS'(STEP);
      end
      if (tie_w) begin
        linked_d[PT] = 1'b1;
        slot_d[PT]   = slot_d[STEP];
      end
    end else begin
      linked_d[STEP] = 1'b0;
    end
  end

  // Count free bits, less one for each tie
  assign cnt_d = cnt_i + CNT_BITS'(counts_w) - CNT_BITS'(tie_w);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      item_q   <= item_i;
      linked_q <= linked_d;
      slot_q   <= slot_d;
      cnt_q    <= cnt_d;
    end
  end

  assign valid_o  = valid_q;
  assign item_o   = item_q;
  assign linked_o = linked_q;
  assign slot_o   = slot_q;
  assign cnt_o    = cnt_q;

endmodule

@@ sv/srde_fill_stage.sv @@
module srde_fill_stage import srde_pkg::*; #(
  parameter int WORD_BITS = 16,
  parameter int SLOT_BITS = 4,
  parameter int CNT_BITS  = 5,
  parameter int LANE_BASE = 0
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  item_t                               item_i,
  input  logic [WORD_BITS-1:0]                linked_i,
  input  logic [WORD_BITS-1:0][SLOT_BITS-1:0] slot_i,
  input  logic [CNT_BITS-1:0]                 cnt_i,
  input  logic [CNT_BITS-1:0]                 k_i,
  input  logic [WORD_BITS-1:0]                g_i,
  output logic                                valid_o,
  output item_t                               item_o,
  output logic [WORD_BITS-1:0]                linked_o,
  output logic [WORD_BITS-1:0][SLOT_BITS-1:0] slot_o,
  output logic [CNT_BITS-1:0]                 cnt_o,
  output logic [CNT_BITS-1:0]                 k_o,
  output logic [WORD_BITS-1:0]                g_o
);

  localparam int LANE_CNT = (WORD_BITS - LANE_BASE < FILL_LANES) ?
                            (WORD_BITS - LANE_BASE) : FILL_LANES;

  logic                                valid_q;
  item_t                               item_q;
  logic [WORD_BITS-1:0]                linked_q;
  logic [WORD_BITS-1:0][SLOT_BITS-1:0] slot_q;
  logic [CNT_BITS-1:0]                 cnt_q;
  logic [CNT_BITS-1:0]                 k_d, k_q;
  logic [WORD_BITS-1:0]                g_d, g_q;

  // Flip each free bit of this group by the next index bit, in ascending order
  always_comb begin
    k_d = k_i;
    g_d = g_i;
    for (int l = 0; l < LANE_CNT; l++) begin
      if (linked_i[LANE_BASE+l] && slot_i[LANE_BASE+l] == SLOT_BITS'(LANE_BASE + l)) begin
        if (k_d < CNT_BITS'(INDEX_BITS)) begin
          g_d[LANE_BASE+l] = g_d[LANE_BASE+l] ^
                             item_i.choice_index[k_d[IDX_SEL_BITS-1:0]];
        end
        k_d = k_d + CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      item_q   <= item_i;
      linked_q <= linked_i;
      slot_q   <= slot_i;
      cnt_q    <= cnt_i;
      k_q      <= k_d;
      g_q      <= g_d;
    end
  end

  assign valid_o  = valid_q;
  assign item_o   = item_q;
  assign linked_o = linked_q;
  assign slot_o   = slot_q;
  assign cnt_o    = cnt_q;
  assign k_o      = k_q;
  assign g_o      = g_q;

endmodule

@@ sv/srde_tie_init.sv @@
module srde_tie_init import srde_pkg::*; #(
  parameter int WORD_BITS = 16,
  parameter int SLOT_BITS = 4,
  parameter int CNT_BITS  = 5
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  item_t                               item_i,
  input  logic [WORD_BITS-1:0]                linked_i,
  input  logic [WORD_BITS-1:0][SLOT_BITS-1:0] slot_i,
  input  logic [CNT_BITS-1:0]                 cnt_i,
  input  logic [WORD_BITS-1:0]                g_i,
  output logic                                valid_o,
  output item_t                               item_o,
  output logic [CNT_BITS-1:0]                 cnt_o,
  output logic [WORD_BITS-1:0]                g_o,
  output logic [WORD_BITS-1:0][SLOT_BITS-1:0] ptr_o,
  output logic [WORD_BITS-1:0]                done_o
);

  logic [WORD_BITS-1:0]                tied_w;
  logic [SLOT_BITS-1:0]                src_w;
  logic                                valid_q;
  item_t                               item_q;
  logic [CNT_BITS-1:0]                 cnt_q;
  logic [WORD_BITS-1:0]                g_q;
  logic [WORD_BITS-1:0][SLOT_BITS-1:0] ptr_d, ptr_q;
  logic [WORD_BITS-1:0]                done_d, done_q;

  // Mark bits that copy a partner
  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      tied_w[j] = linked_i[j] && (slot_i[j] != SLOT_BITS'(j));
    end
  end

  // Point each bit at its partner; resolved once the partner is not an
  // earlier tied bit, whose own final value would be needed
  always_comb begin
    src_w = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      src_w     = slot_i[j];
      ptr_d[j]  = tied_w[j] ? src_w : SLOT_BITS'(j);
      done_d[j] = !tied_w[j] || !(tied_w[src_w] && (src_w < SLOT_BITS'(j)));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      item_q <= item_i;
      cnt_q  <= cnt_i;
      g_q    <= g_i;
      ptr_q  <= ptr_d;
      done_q <= done_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
  assign cnt_o   = cnt_q;
  assign g_o     = g_q;
  assign ptr_o   = ptr_q;
  assign done_o  = done_q;

endmodule

@@ sv/srde_jump_stage.sv @@
module srde_jump_stage import srde_pkg::*; #(
  parameter int WORD_BITS = 16,
  parameter int SLOT_BITS = 4,
  parameter int CNT_BITS  = 5
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  item_t                               item_i,
  input  logic [CNT_BITS-1:0]                 cnt_i,
  input  logic [WORD_BITS-1:0]                g_i,
  input  logic [WORD_BITS-1:0][SLOT_BITS-1:0] ptr_i,
  input  logic [WORD_BITS-1:0]                done_i,
  output logic                                valid_o,
  output item_t                               item_o,
  output logic [CNT_BITS-1:0]                 cnt_o,
  output logic [WORD_BITS-1:0]                g_o,
  output logic [WORD_BITS-1:0][SLOT_BITS-1:0] ptr_o,
  output logic [WORD_BITS-1:0]                done_o
);

  logic [SLOT_BITS-1:0]                hop_w;
  logic                                valid_q;
  item_t                               item_q;
  logic [CNT_BITS-1:0]                 cnt_q;
  logic [WORD_BITS-1:0]                g_q;
  logic [WORD_BITS-1:0][SLOT_BITS-1:0] ptr_d, ptr_q;
  logic [WORD_BITS-1:0]                done_d, done_q;

  // Double every open link: take over the pointer of the bit pointed at
  always_comb begin
    hop_w  = '0;
    ptr_d  = ptr_i;
    done_d = done_i;
    for (int j = 0; j < WORD_BITS; j++) begin
      hop_w = ptr_i[j];
      if (!done_i[j]) begin
        ptr_d[j]  = ptr_i[hop_w];
        done_d[j] = done_i[hop_w];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      item_q <= item_i;
      cnt_q  <= cnt_i;
      g_q    <= g_i;
      ptr_q  <= ptr_d;
      done_q <= done_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
  assign cnt_o   = cnt_q;
  assign g_o     = g_q;
  assign ptr_o   = ptr_q;
  assign done_o  = done_q;

endmodule

@@ sv/simon_round_difference_enumerator.sv @@
// One-round difference enumerator for a Simon-style round, fully pipelined.
// Input channel: drive left_diff_i, right_diff_i and choice_index_i with
// start high; a word is taken at every rising edge where start is high and
// busy is low. busy stays low, so a new word may enter in every cycle.
// Output channel: done_o is high for exactly one cycle per word, with
// next_left_o, next_right_o, weight_o and choice_ok_o valid in that cycle.
// The receiver cannot stall; it must take each word as it appears.
// Results leave in the order the words came in.
// Stages: WORD_BITS scan stages (one bit position each), ceil(WORD_BITS/8)
// fill stages (eight positions each), one tie setup stage, ceil(log2
// WORD_BITS) pointer jumping stages and one output register; the pipeline
// takes one word per cycle.
// Reset clears all valid bits at once; words in flight are dropped and
// no done_o pulse follows until a new word is taken.
module simon_round_difference_enumerator import srde_pkg::*; #(
  parameter int WORD_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [FIELD_BITS-1:0]  left_diff_i,
  input  logic [FIELD_BITS-1:0]  right_diff_i,
  input  logic [FIELD_BITS-1:0]  choice_index_i,
  output logic                   done_o,
  output logic [FIELD_BITS-1:0]  next_left_o,
  output logic [FIELD_BITS-1:0]  next_right_o,
  output logic [WEIGHT_BITS-1:0] weight_o,
  output logic                   choice_ok_o
);

  localparam int SLOT_BITS   = $clog2(WORD_BITS);
  localparam int CNT_BITS    = $clog2(WORD_BITS + 1);
  localparam int FILL_STAGES = (WORD_BITS + FILL_LANES - 1) / FILL_LANES;
  localparam int JUMP_STAGES = $clog2(WORD_BITS);
  localparam int LATENCY     = WORD_BITS + FILL_STAGES + JUMP_STAGES + 2;

  // Scan pipeline
  logic [WORD_BITS:0]                  scan_v;
  item_t                               scan_item   [WORD_BITS+1];
  logic [WORD_BITS-1:0]                scan_linked [WORD_BITS+1];
  logic [WORD_BITS-1:0][SLOT_BITS-1:0] scan_slot   [WORD_BITS+1];
  logic [CNT_BITS-1:0]                 scan_cnt    [WORD_BITS+1];

  // Fill pipeline
  logic [FILL_STAGES:0]                fill_v;
  item_t                               fill_item   [FILL_STAGES+1];
  logic [WORD_BITS-1:0]                fill_linked [FILL_STAGES+1];
  logic [WORD_BITS-1:0][SLOT_BITS-1:0] fill_slot   [FILL_STAGES+1];
  logic [CNT_BITS-1:0]                 fill_cnt    [FILL_STAGES+1];
  logic [CNT_BITS-1:0]                 fill_k      [FILL_STAGES+1];
  logic [WORD_BITS-1:0]                fill_g      [FILL_STAGES+1];

  // Pointer jumping pipeline
  logic [JUMP_STAGES:0]                jump_v;
  item_t                               jump_item [JUMP_STAGES+1];
  logic [CNT_BITS-1:0]                 jump_cnt  [JUMP_STAGES+1];
  logic [WORD_BITS-1:0]                jump_g    [JUMP_STAGES+1];
  logic [WORD_BITS-1:0][SLOT_BITS-1:0] jump_ptr  [JUMP_STAGES+1];
  logic [WORD_BITS-1:0]                jump_done [JUMP_STAGES+1];

  logic [WORD_BITS-1:0]   left_w;
  logic [WORD_BITS-1:0]   base_w;
  logic [FIELD_BITS-1:0]  res_w;
  item_t                  last_item_w;
  logic [CNT_BITS-1:0]    last_cnt_w;
  logic                   done_q;
  logic [FIELD_BITS-1:0]  next_left_d, next_left_q;
  logic [FIELD_BITS-1:0]  next_right_q;
  logic [WEIGHT_BITS-1:0] weight_d, weight_q;
  logic                   choice_ok_d, choice_ok_q;

  // Take a word every cycle
  assign busy = 1'b0;

  assign scan_v[0]      = start;
  assign scan_item[0]   = '{left_diff: left_diff_i, right_diff: right_diff_i,
                            choice_index: choice_index_i};
  assign scan_linked[0] = '0;
  assign scan_slot[0]   = '0;
  assign scan_cnt[0]    = '0;

  // Walk the bit positions in ascending order, one per stage
  for (genvar s = 0; s < WORD_BITS; s++) begin : g_scan
    srde_scan_stage #(
      .WORD_BITS(WORD_BITS),
      .SLOT_BITS(SLOT_BITS),
      .CNT_BITS (CNT_BITS),
      .STEP     (s)
    ) u_scan (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (scan_v[s]),
      .item_i  (scan_item[s]),
      .linked_i(scan_linked[s]),
      .slot_i  (scan_slot[s]),
      .cnt_i   (scan_cnt[s]),
      .valid_o (scan_v[s+1]),
      .item_o  (scan_item[s+1]),
      .linked_o(scan_linked[s+1]),
      .slot_o  (scan_slot[s+1]),
      .cnt_o   (scan_cnt[s+1])
    );
  end

  // Form the base output difference: (x<<<1 & x<<<8) ^ x<<<2
  assign left_w = WORD_BITS'(scan_item[WORD_BITS].left_diff);
  assign base_w = (((left_w << ROT_AND_A) | (left_w >> (WORD_BITS - ROT_AND_A))) &
                   ((left_w << ROT_AND_B) | (left_w >> (WORD_BITS - ROT_AND_B)))) ^
                  ((left_w << ROT_XOR) | (left_w >> (WORD_BITS - ROT_XOR)));

  assign fill_v[0]      = scan_v[WORD_BITS];
  assign fill_item[0]   = scan_item[WORD_BITS];
  assign fill_linked[0] = scan_linked[WORD_BITS];
  assign fill_slot[0]   = scan_slot[WORD_BITS];
  assign fill_cnt[0]    = scan_cnt[WORD_BITS];
  assign fill_k[0]      = '0;
  assign fill_g[0]      = base_w;

  // Place index bits into free positions, eight positions per stage
  for (genvar f = 0; f < FILL_STAGES; f++) begin : g_fill
    srde_fill_stage #(
      .WORD_BITS(WORD_BITS),
      .SLOT_BITS(SLOT_BITS),
      .CNT_BITS (CNT_BITS),
      .LANE_BASE(f * FILL_LANES)
    ) u_fill (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (fill_v[f]),
      .item_i  (fill_item[f]),
      .linked_i(fill_linked[f]),
      .slot_i  (fill_slot[f]),
      .cnt_i   (fill_cnt[f]),
      .k_i     (fill_k[f]),
      .g_i     (fill_g[f]),
      .valid_o (fill_v[f+1]),
      .item_o  (fill_item[f+1]),
      .linked_o(fill_linked[f+1]),
      .slot_o  (fill_slot[f+1]),
      .cnt_o   (fill_cnt[f+1]),
      .k_o     (fill_k[f+1]),
      .g_o     (fill_g[f+1])
    );
  end

  // Set up tie pointers
  srde_tie_init #(
    .WORD_BITS(WORD_BITS),
    .SLOT_BITS(SLOT_BITS),
    .CNT_BITS (CNT_BITS)
  ) u_tie_init (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fill_v[FILL_STAGES]),
    .item_i  (fill_item[FILL_STAGES]),
    .linked_i(fill_linked[FILL_STAGES]),
    .slot_i  (fill_slot[FILL_STAGES]),
    .cnt_i   (fill_cnt[FILL_STAGES]),
    .g_i     (fill_g[FILL_STAGES]),
    .valid_o (jump_v[0]),
    .item_o  (jump_item[0]),
    .cnt_o   (jump_cnt[0]),
    .g_o     (jump_g[0]),
    .ptr_o   (jump_ptr[0]),
    .done_o  (jump_done[0])
  );

  // Resolve tie chains by pointer doubling
  for (genvar p = 0; p < JUMP_STAGES; p++) begin : g_jump
    srde_jump_stage #(
      .WORD_BITS(WORD_BITS),
      .SLOT_BITS(SLOT_BITS),
      .CNT_BITS (CNT_BITS)
    ) u_jump (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(jump_v[p]),
      .item_i (jump_item[p]),
      .cnt_i  (jump_cnt[p]),
      .g_i    (jump_g[p]),
      .ptr_i  (jump_ptr[p]),
      .done_i (jump_done[p]),
      .valid_o(jump_v[p+1]),
      .item_o (jump_item[p+1]),
      .cnt_o  (jump_cnt[p+1]),
      .g_o    (jump_g[p+1]),
      .ptr_o  (jump_ptr[p+1]),
      .done_o (jump_done[p+1])
    );
  end

  assign last_item_w = jump_item[JUMP_STAGES];
  assign last_cnt_w  = jump_cnt[JUMP_STAGES];

  // Read each low bit through its resolved pointer
  always_comb begin
    for (int j = 0; j < FIELD_BITS; j++) begin
      res_w[j] = jump_g[JUMP_STAGES][jump_ptr[JUMP_STAGES][j]];
    end
  end

  // Build the result word; saturate the weight, and any index is in range
  // once the weight reaches the index width
  assign next_left_d = last_item_w.right_diff ^ res_w;
  assign weight_d    = (last_cnt_w > CNT_BITS'(WEIGHT_MAX)) ?
                       WEIGHT_BITS'(WEIGHT_MAX) : WEIGHT_BITS'(last_cnt_w);
  assign choice_ok_d = (last_cnt_w >= CNT_BITS'(INDEX_BITS)) ||
                       ((last_item_w.choice_index >> last_cnt_w[IDX_SEL_BITS-1:0]) == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= jump_v[JUMP_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (jump_v[JUMP_STAGES]) begin
      next_left_q  <= next_left_d;
      next_right_q <= last_item_w.left_diff;
      weight_q     <= weight_d;
      choice_ok_q  <= choice_ok_d;
    end
  end

  assign done_o       = done_q;
  assign next_left_o  = next_left_q;
  assign next_right_o = next_right_q;
  assign weight_o     = weight_q;
  assign choice_ok_o  = choice_ok_q;

`ifndef SYNTHESIS
  a_latency_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##LATENCY done_o)
    else $error("accepted word produced no result at the expected cycle");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, LATENCY))
    else $error("result word without a matching accepted word");

  a_right_passes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> next_right_o == $past(left_diff_i, LATENCY))
    else $error("next_right does not match the accepted left difference");

  a_chains_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    jump_v[JUMP_STAGES] |-> (&jump_done[JUMP_STAGES]))
    else $error("tie chain left unresolved after pointer jumping");

  a_heavy_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && weight_o >= WEIGHT_BITS'(INDEX_BITS)) |-> choice_ok_o)
    else $error("index flagged out of range at full weight");
`endif

endmodule
